// ===== rtl/ffsa_pkg.sv =====
// ----------------------------------------------------------------------------
// ffsa_pkg
// Shared types, sizes and codes of the first-fit segment allocator.
// ----------------------------------------------------------------------------
package ffsa_pkg;

	// pool geometry; UNIT_WORDS must be a power of two
	localparam int SEGMENTS   = 64;
	localparam int UNIT_WORDS = 1024;
	localparam int SLOTS      = 16;

	localparam int SEG_W   = $clog2(SEGMENTS);
	localparam int CNT_W   = SEG_W + 1;
	localparam int SLOT_W  = 4;
	localparam int WORDS_W = 20;
	localparam int UNIT_SH = $clog2(UNIT_WORDS);
	localparam int NEED_W  = WORDS_W - UNIT_SH + 1;
	localparam int SLOTD_W = SEG_W + CNT_W;

	// operation codes
	localparam logic [1:0] OP_ALLOC    = 2'd0;
	localparam logic [1:0] OP_FREE     = 2'd1;
	localparam logic [1:0] OP_FREE_ALL = 2'd2;
	localparam logic [1:0] OP_UNUSED   = 2'd3;

	// status codes
	localparam logic [1:0] ST_OK         = 2'd0;
	localparam logic [1:0] ST_NO_SLOT    = 2'd1;
	localparam logic [1:0] ST_NO_SPACE   = 2'd2;
	localparam logic [1:0] ST_BAD_HANDLE = 2'd3;

	typedef struct packed {
		logic [1:0]         operation;
		logic [WORDS_W-1:0] request_words;
		logic [SLOT_W-1:0]  handle;
	} req_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [SLOT_W-1:0] granted_handle;
		logic [SEG_W-1:0]  start_segment;
		logic [CNT_W-1:0]  segment_count;
	} res_t;

	// slot table commands from the sequencer
	typedef struct packed {
		logic              set;
		logic              clr;
		logic              clr_all;
		logic [SLOT_W-1:0] idx;
	} slot_cmd_t;

	// slot table status to the sequencer
	typedef struct packed {
		logic              any_free;
		logic [SLOT_W-1:0] free_idx;
		logic [SLOTS-1:0]  in_use;
	} slot_stat_t;

endpackage

// ===== rtl/ffsa_ram.sv =====
// ----------------------------------------------------------------------------
// ffsa_ram
// Generic single-clock RAM, one write port and one read port, registered read.
// ----------------------------------------------------------------------------
module ffsa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/ffsa_slots.sv =====
// ----------------------------------------------------------------------------
// ffsa_slots
// Slot in-use flags with lowest-free-slot search.
// ----------------------------------------------------------------------------
module ffsa_slots import ffsa_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  slot_cmd_t  cmd,
	output slot_stat_t stat
);

	logic [SLOTS-1:0] in_use_q;

	// flag updates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_use_q <= '0;
		end else if (cmd.clr_all) begin
			in_use_q <= '0;
		end else begin
			if (cmd.set) begin
				in_use_q[cmd.idx] <= 1'b1;
			end
			if (cmd.clr) begin
				in_use_q[cmd.idx] <= 1'b0;
			end
		end
	end

	// priority search, lowest index wins
	always_comb begin
		stat.any_free = 1'b0;
		stat.free_idx = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (!in_use_q[i]) begin
				stat.any_free = 1'b1;
				stat.free_idx = SLOT_W'(i);
			end
		end
		stat.in_use = in_use_q;
	end

endmodule

// ===== rtl/ffsa_ctrl.sv =====
// ----------------------------------------------------------------------------
// ffsa_ctrl
// Sequencer: scans, marks and clears the segment bitmap memory and keeps the
// slot table memory.
// ----------------------------------------------------------------------------
module ffsa_ctrl import ffsa_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  req_t               req,
	output logic               done,
	output res_t               res,
	// segment bitmap memory
	output logic               seg_we,
	output logic [SEG_W-1:0]   seg_waddr,
	output logic               seg_wdata,
	output logic               seg_re,
	output logic [SEG_W-1:0]   seg_raddr,
	input  logic               seg_rdata,
	// slot table memory
	output logic               slot_we,
	output logic [SLOT_W-1:0]  slot_waddr,
	output logic [SLOTD_W-1:0] slot_wdata,
	output logic               slot_re,
	output logic [SLOT_W-1:0]  slot_raddr,
	input  logic [SLOTD_W-1:0] slot_rdata,
	// slot flags
	output slot_cmd_t          slot_cmd,
	input  slot_stat_t         slot_stat
);

	localparam logic [2:0] S_IDLE    = 3'd0;
	localparam logic [2:0] S_SWEEP   = 3'd1;
	localparam logic [2:0] S_SCAN    = 3'd2;
	localparam logic [2:0] S_MARK    = 3'd3;
	localparam logic [2:0] S_FREE_RD = 3'd4;
	localparam logic [2:0] S_UNMARK  = 3'd5;

	localparam logic [SEG_W-1:0] SEG_LAST = SEG_W'(SEGMENTS - 1);

	logic [2:0]       state_q;
	logic [CNT_W-1:0] addr_q;
	logic             rvalid_s1;
	logic [SEG_W-1:0] ridx_s1;
	logic             quiet_q;
	logic             done_q;
	res_t             res_q;
	logic [CNT_W-1:0] run_q;
	logic [CNT_W-1:0] need_q;
	logic [SLOT_W-1:0] slot_q;
	logic [SEG_W-1:0] first_q;
	logic [SEG_W-1:0] end_q;
	logic [CNT_W-1:0] wr_q;
	logic [CNT_W-1:0] rem_q;
	logic [CNT_W-1:0] cnt_q;

	logic              accept;
	logic [NEED_W-1:0] need_raw;
	logic [NEED_W-1:0] need_c;
	logic              fits;
	logic              alloc_go;
	logic              free_go;
	logic              last_rd;
	logic              found;
	logic [CNT_W-1:0]  first_c;
	logic              mark_end;
	logic              unmark_end;
	res_t              imm_res;

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;
	assign done   = done_q;
	assign res    = res_q;

	// segments needed: ceiling of words over the segment size, at least one
	always_comb begin
		need_raw = {1'b0, req.request_words[WORDS_W-1:UNIT_SH]}
		         + NEED_W'(|req.request_words[UNIT_SH-1:0]);
		need_c   = (need_raw == '0) ? NEED_W'(1) : need_raw;
		fits     = (need_c <= NEED_W'(SEGMENTS));
	end

	assign alloc_go = slot_stat.any_free && fits;
	assign free_go  = slot_stat.in_use[req.handle];

	// scan bookkeeping on the read data of the previous cycle
	assign last_rd    = rvalid_s1 && (ridx_s1 == SEG_LAST);
	assign found      = (state_q == S_SCAN) && rvalid_s1 && !seg_rdata
	                 && ((run_q + CNT_W'(1)) == need_q);
	assign first_c    = {1'b0, ridx_s1} + CNT_W'(1) - need_q;
	assign mark_end   = (wr_q[SEG_W-1:0] == end_q);
	assign unmark_end = (rem_q == CNT_W'(1));

	// result of an operation decided at the transfer
	always_comb begin
		imm_res = '0;
		case (req.operation)
			OP_ALLOC: begin
				imm_res.status = slot_stat.any_free ? ST_NO_SPACE : ST_NO_SLOT;
			end
			OP_FREE: begin
				imm_res.status = ST_BAD_HANDLE;
			end
			default: begin
				imm_res.status = ST_OK;
			end
		endcase
	end

	// segment memory ports; sweep writes trail reads by one entry, so a read
	// never meets a write to the same segment
	always_comb begin
		seg_re    = ((state_q == S_SWEEP) || (state_q == S_SCAN))
		         && (addr_q < CNT_W'(SEGMENTS));
		seg_raddr = addr_q[SEG_W-1:0];
		seg_we    = 1'b0;
		seg_waddr = wr_q[SEG_W-1:0];
		seg_wdata = 1'b0;
		case (state_q)
			S_SWEEP: begin
				seg_we    = rvalid_s1;
				seg_waddr = ridx_s1;
			end
			S_MARK: begin
				seg_we    = 1'b1;
				seg_wdata = 1'b1;
			end
			S_UNMARK: begin
				seg_we = (wr_q < CNT_W'(SEGMENTS));
			end
			default: begin
				seg_we = 1'b0;
			end
		endcase
	end

	// slot table memory and flags
	always_comb begin
		slot_re          = accept && (req.operation == OP_FREE);
		slot_raddr       = req.handle;
		slot_we          = (state_q == S_MARK) && mark_end;
		slot_waddr       = slot_q;
		slot_wdata       = {first_q, need_q};
		slot_cmd.set     = slot_we;
		slot_cmd.clr     = (state_q == S_UNMARK) && unmark_end;
		slot_cmd.clr_all = accept && (req.operation == OP_FREE_ALL);
		slot_cmd.idx     = slot_q;
	end

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_SWEEP;
			addr_q    <= '0;
			rvalid_s1 <= 1'b0;
			quiet_q   <= 1'b1;
			done_q    <= 1'b0;
		end else begin
			done_q    <= 1'b0;
			rvalid_s1 <= seg_re;
			if (seg_re) begin
				addr_q <= addr_q + CNT_W'(1);
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						addr_q <= '0;
						case (req.operation)
							OP_ALLOC: begin
								if (alloc_go) state_q <= S_SCAN;
								else          done_q  <= 1'b1;
							end
							OP_FREE: begin
								if (free_go) state_q <= S_FREE_RD;
								else         done_q  <= 1'b1;
							end
							OP_FREE_ALL: begin
								state_q <= S_SWEEP;
								quiet_q <= 1'b0;
							end
							default: begin
								done_q <= 1'b1;
							end
						endcase
					end
				end
				S_SWEEP: begin
					if (last_rd) begin
						state_q <= S_IDLE;
						done_q  <= !quiet_q;
						quiet_q <= 1'b0;
					end
				end
				S_SCAN: begin
					if (found) begin
						state_q <= S_MARK;
					end else if (last_rd) begin
						state_q <= S_IDLE;
						done_q  <= 1'b1;
					end
				end
				S_MARK: begin
					if (mark_end) begin
						state_q <= S_IDLE;
						done_q  <= 1'b1;
					end
				end
				S_FREE_RD: begin
					state_q <= S_UNMARK;
				end
				S_UNMARK: begin
					if (unmark_end) begin
						state_q <= S_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// working registers and result
	always_ff @(posedge clk) begin
		ridx_s1 <= seg_raddr;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					need_q <= CNT_W'(need_c);
					slot_q <= (req.operation == OP_FREE) ? req.handle : slot_stat.free_idx;
					run_q  <= '0;
					cnt_q  <= '0;
					res_q  <= imm_res;
				end
			end
			S_SWEEP: begin
				if (rvalid_s1 && seg_rdata) begin
					cnt_q <= cnt_q + CNT_W'(1);
				end
				if (last_rd) begin
					res_q        <= '0;
					res_q.status <= ST_OK;
					res_q.segment_count <= cnt_q + CNT_W'(seg_rdata);
				end
			end
			S_SCAN: begin
				if (rvalid_s1) begin
					run_q <= seg_rdata ? '0 : run_q + CNT_W'(1);
				end
				if (found) begin
					first_q <= first_c[SEG_W-1:0];
					end_q   <= ridx_s1;
					wr_q    <= first_c;
				end else if (last_rd) begin
					res_q        <= '0;
					res_q.status <= ST_NO_SPACE;
				end
			end
			S_MARK: begin
				wr_q <= wr_q + CNT_W'(1);
				if (mark_end) begin
					res_q <= '{ST_OK, slot_q, first_q, need_q};
				end
			end
			S_FREE_RD: begin
				first_q <= slot_rdata[SLOTD_W-1:CNT_W];
				need_q  <= slot_rdata[CNT_W-1:0];
				rem_q   <= slot_rdata[CNT_W-1:0];
				wr_q    <= {1'b0, slot_rdata[SLOTD_W-1:CNT_W]};
			end
			S_UNMARK: begin
				wr_q  <= wr_q + CNT_W'(1);
				rem_q <= rem_q - CNT_W'(1);
				if (unmark_end) begin
					res_q <= '{ST_OK, slot_q, first_q, need_q};
				end
			end
			default: begin
				res_q <= res_q;
			end
		endcase
	end

endmodule

// ===== rtl/first_fit_segment_allocator_top.sv =====
// ----------------------------------------------------------------------------
// first_fit_segment_allocator_top
// First-fit allocator of contiguous segments with a small client slot table.
// ----------------------------------------------------------------------------
//
//   channel   signals             transfer
//   --------  ------------------  ------------------------------------------
//   command   start, busy, req    edge with start high and busy low
//   result    done, res           edge ending the single cycle done is high
//
// - allocate: the scan reads the segment bitmap memory one segment per cycle
//   (up to 64), then marks one per cycle
// - free: one bitmap write per segment released
// - free all, and an allocate that finds no run: one bitmap pass
// - other failures and unused operations: result in the cycle after the transfer
// - after reset busy stays high while the bitmap is cleared
// - results cannot be stalled; one command is in flight at a time
//
module first_fit_segment_allocator_top import ffsa_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  req_t req,
	output logic done,
	output res_t res
);

	logic               seg_we;
	logic [SEG_W-1:0]   seg_waddr;
	logic               seg_wdata;
	logic               seg_re;
	logic [SEG_W-1:0]   seg_raddr;
	logic               seg_rdata;
	logic               slot_we;
	logic [SLOT_W-1:0]  slot_waddr;
	logic [SLOTD_W-1:0] slot_wdata;
	logic               slot_re;
	logic [SLOT_W-1:0]  slot_raddr;
	logic [SLOTD_W-1:0] slot_rdata;
	slot_cmd_t          slot_cmd;
	slot_stat_t         slot_stat;

	// sequencer
	ffsa_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.req        (req),
		.done       (done),
		.res        (res),
		.seg_we     (seg_we),
		.seg_waddr  (seg_waddr),
		.seg_wdata  (seg_wdata),
		.seg_re     (seg_re),
		.seg_raddr  (seg_raddr),
		.seg_rdata  (seg_rdata),
		.slot_we    (slot_we),
		.slot_waddr (slot_waddr),
		.slot_wdata (slot_wdata),
		.slot_re    (slot_re),
		.slot_raddr (slot_raddr),
		.slot_rdata (slot_rdata),
		.slot_cmd   (slot_cmd),
		.slot_stat  (slot_stat)
	);

	// segment busy bitmap
	ffsa_ram #(
		.WIDTH (1),
		.DEPTH (SEGMENTS)
	) u_seg_ram (
		.clk   (clk),
		.we    (seg_we),
		.waddr (seg_waddr),
		.wdata (seg_wdata),
		.re    (seg_re),
		.raddr (seg_raddr),
		.rdata (seg_rdata)
	);

	// slot start and length
	ffsa_ram #(
		.WIDTH (SLOTD_W),
		.DEPTH (SLOTS)
	) u_slot_ram (
		.clk   (clk),
		.we    (slot_we),
		.waddr (slot_waddr),
		.wdata (slot_wdata),
		.re    (slot_re),
		.raddr (slot_raddr),
		.rdata (slot_rdata)
	);

	// slot in-use flags
	ffsa_slots u_slots (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (slot_cmd),
		.stat   (slot_stat)
	);

endmodule

// ===== rtl/ffsa_chk.sv =====
// ----------------------------------------------------------------------------
// ffsa_chk
// Port-level checks of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
module ffsa_chk import ffsa_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input req_t req,
	input logic done,
	input res_t res
);

	// a result only follows a transfer or ongoing work
	a_done_cause: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(busy) || $past(start)))
		else $error("result without a command");

	// a transfer leads to work or a result
	a_accept_next: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy || done))
		else $error("command dropped");

	// failures report no segments
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (res.status != ST_OK)) |-> (res.segment_count == '0))
		else $error("failure with segment count");

	// a granted or released run lies inside the pool
	a_run_inside: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (res.status == ST_OK)) |->
		((8'(res.start_segment) + 8'(res.segment_count)) <= 8'(SEGMENTS)))
		else $error("run outside the pool");

endmodule

bind first_fit_segment_allocator_top ffsa_chk u_chk (.*);
